### src/utf8_to_ucs2_decoder_macros.svh
// Assertion macros for the checker of the UTF-8 to UCS-2 decoder.
// Depends on nothing; included by the checker file.
`ifndef UTF8_TO_UCS2_DECODER_MACROS_SVH
`define UTF8_TO_UCS2_DECODER_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define U8DEC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decoder assertion failed");

// Consequent in the cycle after the antecedent.
`define U8DEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder assertion failed");

`endif

### src/u8dec_pkg.sv
// Package of the UTF-8 to UCS-2 decoder: byte classes, masks and the lead byte decode.
// Depends on nothing.
package u8dec_pkg;

    localparam logic [7:0]  TOP_BIT    = 8'h80;
    localparam logic [7:0]  SECOND_BIT = 8'h40;
    localparam logic [7:0]  PAYLOAD6   = 8'h3f;

    typedef logic [2:0]  trail_cnt_t;
    typedef logic [15:0] unit_t;

    typedef enum logic [1:0] {
        CLASS_ASCII,
        CLASS_TRAIL,
        CLASS_LEAD
    } byte_class_t;

    typedef struct packed {
        trail_cnt_t trail;
        logic [7:0] payload;
    } lead_t;

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t c;
        if ((b & TOP_BIT) == 8'h00)
            c = CLASS_ASCII;
        else if ((b & SECOND_BIT) == 8'h00)
            c = CLASS_TRAIL;
        else
            c = CLASS_LEAD;
        return c;
    endfunction

    // The count of leading ones sets the trail count; the bits below them are payload.
    function automatic lead_t decode_lead(input logic [7:0] b);
        lead_t      r;
        logic [3:0] ones;
        logic       stop;
        ones = 4'd0;
        stop = 1'b0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!stop && b[i])
                ones = ones + 4'd1;
            else
                stop = 1'b1;
        end
        r.trail   = 3'(ones - 4'd1);
        r.payload = b & (8'hff >> ones);
        return r;
    endfunction

endpackage

### src/utf8_to_ucs2_decoder.sv
// Top level of the UTF-8 to UCS-2 decoder: input register, decode logic, result register.
// Depends on u8dec_pkg.
//
//   Channel | Handshake                | Payload
//   --------+--------------------------+-----------------------------
//   input   | in_valid / in_stall      | byte_in[7:0]
//   output  | out_valid / out_stall    | code_unit[15:0], truncated
//
// One byte is accepted per cycle unless stalled; units come out of the result register.
// The sustained rate of one byte per cycle is set by the single decode stage.
// Reset clears the sequence state and both stage valid flags.
// A stalled output holds the decode stage, which in turn stalls the input.
module utf8_to_ucs2_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] code_unit,
    output logic        truncated
);
    import u8dec_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    trail_cnt_t  trail_left_reg, trail_left_next;
    unit_t       accum_reg, accum_next;
    logic        out_valid_reg;
    unit_t       code_unit_reg;
    logic        truncated_reg;

    logic        advance;
    logic        emit;
    unit_t       unit_val;
    logic        trunc_val;
    unit_t       shifted;
    lead_t       lead;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    assign shifted = {accum_reg[9:0], byte_reg[5:0] & PAYLOAD6[5:0]};
    assign lead    = decode_lead(byte_reg);

    always_comb
    begin
        trail_left_next = trail_left_reg;
        accum_next      = accum_reg;
        emit            = 1'b0;
        unit_val        = accum_reg;
        trunc_val       = 1'b0;
        case (classify(byte_reg))
            CLASS_ASCII:
            begin
                trail_left_next = '0;
                emit            = 1'b1;
                unit_val        = {8'h00, byte_reg};
            end
            CLASS_TRAIL:
            begin
                if (trail_left_reg != '0)
                begin
                    trail_left_next = trail_left_reg - 3'd1;
                    accum_next      = shifted;
                    if (trail_left_reg == 3'd1)
                    begin
                        emit     = 1'b1;
                        unit_val = shifted;
                    end
                end
            end
            CLASS_LEAD:
            begin
                if (trail_left_reg != '0)
                begin
                    trail_left_next = '0;
                    emit            = 1'b1;
                    trunc_val       = 1'b1;
                end
                else
                begin
                    trail_left_next = lead.trail;
                    accum_next      = {8'h00, lead.payload};
                end
            end
            default:
            begin
                trail_left_next = trail_left_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            trail_left_reg <= '0;
            accum_reg      <= '0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                trail_left_reg <= trail_left_next;
                accum_reg      <= accum_next;
            end
            if (advance && emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            byte_reg <= byte_in;
        if (advance && emit)
        begin
            code_unit_reg <= unit_val;
            truncated_reg <= trunc_val;
        end
    end

    assign out_valid = out_valid_reg;
    assign code_unit = code_unit_reg;
    assign truncated = truncated_reg;

endmodule

### src/u8dec_checker.sv
// Port-level checker of the UTF-8 to UCS-2 decoder and its bind to the top level.
// Depends on utf8_to_ucs2_decoder_macros.svh.
`include "utf8_to_ucs2_decoder_macros.svh"

module u8dec_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  byte_in,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] code_unit,
    input logic        truncated
);

    // A stalled result transaction keeps its payload.
    `U8DEC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(code_unit) && $stable(truncated))

    // The input is only stalled by a result that is itself stalled.
    `U8DEC_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

    // A fresh result is traced back to an accepted input transaction.
    `U8DEC_ASSERT_SAME(a_rise_source, clk, rst_n, $rose(out_valid),
        $past(in_valid && !in_stall, 2))

    // An accepted ASCII byte whose result is not held back comes out unchanged.
    `U8DEC_ASSERT_NEXT(a_ascii_plain, clk, rst_n,
        (in_valid && !in_stall && !byte_in[7]) ##1 !out_stall,
        out_valid && !truncated && code_unit == {8'h00, $past(byte_in, 2)})

endmodule

bind utf8_to_ucs2_decoder u8dec_checker u_u8dec_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .byte_in   (byte_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .code_unit (code_unit),
    .truncated (truncated)
);

### bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for utf8_to_ucs2_decoder: directed and random UTF-8 byte streams.
// Expected code units come from a small checker class; depends on u8dec_pkg and the block.
module testbench;

    import u8dec_pkg::*;

    typedef struct packed {
        unit_t unit;
        logic  cut_short;
    } decoded_unit_t;

    class ucs2_unit_checker;
        decoded_unit_t expected_units[$];
        logic [2:0]    trail_left;
        unit_t         partial_unit;
        int            errors;
        int            units_seen;
        int            cut_units_seen;

        function new();
            trail_left     = 3'd0;
            partial_unit   = '0;
            errors         = 0;
            units_seen     = 0;
            cut_units_seen = 0;
        endfunction

        // Returns 1 when the byte is a stray trail byte that the decoder ignores.
        function bit take_byte(input logic [7:0] b);
            decoded_unit_t du;
            int            ones;
            if (!b[7])
            begin
                trail_left = 3'd0;
                du.unit = {8'h00, b};
                du.cut_short = 1'b0;
                expected_units.push_back(du);
                return 1'b0;
            end
            if (!b[6])
            begin
                if (trail_left == 3'd0)
                    return 1'b1;
                trail_left = trail_left - 3'd1;
                partial_unit = {partial_unit[9:0], b[5:0]};
                if (trail_left == 3'd0)
                begin
                    du.unit = partial_unit;
                    du.cut_short = 1'b0;
                    expected_units.push_back(du);
                end
                return 1'b0;
            end
            if (trail_left != 3'd0)
            begin
                trail_left = 3'd0;
                du.unit = partial_unit;
                du.cut_short = 1'b1;
                expected_units.push_back(du);
                return 1'b0;
            end
            ones = 0;
            while (ones < 8 && b[7 - ones])
                ones++;
            partial_unit = {8'h00, b & (8'hff >> ones)};
            trail_left = 3'(ones - 1);
            return 1'b0;
        endfunction

        function void check_unit(input unit_t unit, input logic cut_short);
            decoded_unit_t du;
            units_seen++;
            if (cut_short)
                cut_units_seen++;
            if (expected_units.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected transaction: code_unit=%h truncated=%b", unit, cut_short);
                return;
            end
            du = expected_units.pop_front();
            if (du.unit !== unit || du.cut_short !== cut_short)
            begin
                errors++;
                if (errors <= 10)
                    $display("Mismatch: expected code_unit=%h truncated=%b, got %h %b",
                             du.unit, du.cut_short, unit, cut_short);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  byte_in;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] code_unit;
    logic        truncated;

    ucs2_unit_checker units = new();

    int send_gap_pct;
    int recv_stall_pct;
    int hold_left;
    bit long_hold_req;
    int bytes_used;
    int bytes_sent;
    int leftover;

    utf8_to_ucs2_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .byte_in   (byte_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .code_unit (code_unit),
        .truncated (truncated)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("Timed out with %0d transactions outstanding", units.expected_units.size());
        $display("utf8_to_ucs2_decoder regression: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            units.check_unit(code_unit, truncated);
    end

    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = 400;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
        if (!units.take_byte(b))
            bytes_used++;
    endtask

    task automatic wait_for_units(input int max_cycles);
        int n;
        in_valid <= 1'b0;
        n = 0;
        while (units.expected_units.size() != 0 && n < max_cycles)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    // Mostly well-formed sequences, some cut short, some arbitrary bytes.
    task automatic send_random_chunk();
        int         kind;
        int         pick;
        int         ones;
        int         keep;
        logic [7:0] lead;
        kind = $urandom_range(99);
        if (kind < 15)
        begin
            send_byte(8'($urandom_range(255)));
            return;
        end
        pick = $urandom_range(99);
        ones = (pick < 25) ? 1 : (pick < 50) ? 2 : (pick < 75) ? 3 :
               (pick < 88) ? 4 : $urandom_range(8, 5);
        if (ones == 1)
        begin
            send_byte(8'($urandom_range(127)));
            return;
        end
        lead = (8'hff << (8 - ones)) | (8'($urandom) & (8'hff >> (ones + 1)));
        keep = (kind < 30) ? $urandom_range(ones - 2, 0) : ones - 1;
        send_byte(lead);
        for (int i = 0; i < keep; i++)
            send_byte(8'h80 | 8'($urandom_range(63)));
        if (kind < 30)
        begin
            pick = $urandom_range(2);
            if (pick == 0)
                send_byte(8'($urandom_range(127)));
            else if (pick == 1)
                send_byte(8'hc0 | 8'($urandom_range(63)));
        end
    endtask

    initial
    begin
        logic [7:0] directed[$];
        int         goal;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        byte_in        = 8'h00;
        send_gap_pct   = 25;
        recv_stall_pct = 69;
        long_hold_req  = 1'b0;
        bytes_used     = 0;
        bytes_sent     = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{8'h00, 8'h7f, 8'h80, 8'hc3, 8'ha9, 8'he2, 8'h82, 8'hac,
                     8'hf0, 8'h9f, 8'h98, 8'h80, 8'he2, 8'h82, 8'hc3, 8'he2, 8'h41,
                     8'hff, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf};
        foreach (directed[i])
            send_byte(directed[i]);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_gap_pct   = (phase == 0) ? 25 : (phase == 1) ? 69 : 0;
            recv_stall_pct = (phase == 0) ? 69 : (phase == 1) ? 25 : 0;
            goal = 1600 * (phase + 1) / 3;
            while (bytes_used < goal)
            begin
                if (phase == 0 && bytes_used >= goal / 2 && hold_left == 0 && !long_hold_req
                    && bytes_used < goal / 2 + 10)
                    long_hold_req = 1'b1;
                send_random_chunk();
            end
            if (phase == 1)
                wait_for_units(5000);
        end

        wait_for_units(5000);
        repeat (8) @(posedge clk);
        leftover = units.expected_units.size();
        if (leftover != 0)
            $display("%0d expected transactions never arrived", leftover);
        $display("Sent %0d bytes (%0d decoded), checked %0d code units, %0d of them truncated.",
                 bytes_sent, bytes_used, units.units_seen, units.cut_units_seen);
        if (units.errors == 0 && leftover == 0)
            $display("utf8_to_ucs2_decoder regression: pass");
        else
            $display("utf8_to_ucs2_decoder regression: fail");
        $finish;
    end

endmodule
